>>> design/lrt_pkg.sv
// Package for the lease reservation table: shared types, codes and constants.
// Used by lrt_ctrl, lrt_datapath and lease_reservation_table_top; no dependencies.
package lrt_pkg;

    localparam int TABLE_DEPTH_DEF = 64;

    localparam logic [31:0] LEASE_TIME_RESET = 32'd1000;
    localparam logic [6:0]  LIMIT_RESET      = 7'd64;

    typedef enum logic [2:0] {
        MODE_RESERVE     = 3'd0,
        MODE_COMMIT      = 3'd1,
        MODE_RELEASE     = 3'd2,
        MODE_CLEANUP     = 3'd3,
        MODE_RELEASE_ALL = 3'd4
    } mode_t;

    typedef enum logic [1:0] {
        LS_TENTATIVE = 2'd0,
        LS_COMMITTED = 2'd1,
        LS_EXPIRED   = 2'd2,
        LS_RELEASED  = 2'd3
    } lease_state_t;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_AUTH      = 3'd1,
        ST_NOT_LIVE  = 3'd2,
        ST_CAPACITY  = 3'd3,
        ST_NOT_FOUND = 3'd4,
        ST_EXPIRED   = 3'd5,
        ST_FULL      = 3'd6
    } status_t;

    localparam logic [1:0] CFG_GLOBAL    = 2'd0;
    localparam logic [1:0] CFG_REQUESTER = 2'd1;
    localparam logic [1:0] CFG_SERVICE   = 2'd2;
    localparam logic [1:0] CFG_LEASE     = 2'd3;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_SCAN_RD,
        S_SCAN_EV,
        S_RESERVE_DECIDE,
        S_SLOT_RD,
        S_SLOT_EV,
        S_DONE
    } ctrl_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;        // capture input item
        logic scan_start;  // reset scan index and counters
        logic scan_read;   // issue a read at the scan index
        logic scan_eval;   // evaluate the read entry, advance index
        logic decide;      // finish a reserve
        logic slot_read;   // issue a read at the requested slot
        logic slot_eval;   // evaluate commit or release
        logic finish_simple; // result for items with no scan or slot evaluation
        logic out_load;    // move result into the output register
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [2:0] mode;
        logic       auth;
        logic       scan_last; // the entry under evaluation is the last used one, or a reserve has hit its key
        logic       empty;     // no used entries
        logic       slot_valid;
    } stat_t;

endpackage

>>> design/lease_reservation_table_top.sv
// Top level of the lease reservation table.
// Depends on lrt_pkg, lrt_ctrl, lrt_datapath, lrt_ram.

// One item is worked at a time. Reserve, cleanup and release-all walk the
// used slots through single-port lease memories, with a read state and an
// evaluate state per used slot; a reserve that finds its key stops the walk
// there. Commit and release read the requested slot and evaluate it, and skip
// the evaluation when the slot was never filled; an unauthorized reserve, a
// cleanup or release-all on an empty table, or an unused mode goes straight
// to the result. The result sits in an output register, so a new item is taken
// while it waits, and that item then holds until the register is free.
module lease_reservation_table_top #(
    parameter int TABLE_DEPTH = lrt_pkg::TABLE_DEPTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [2:0]  mode,
    input  logic [31:0] request_key,
    input  logic [15:0] requester_id,
    input  logic [15:0] service_id,
    input  logic        authorized,
    input  logic [5:0]  lease_slot,
    input  logic [47:0] now_ms,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        ok,
    output logic [2:0]  status,
    output logic [5:0]  slot_out,
    output logic        duplicate,
    output logic [48:0] expires_at,
    output logic [1:0]  lease_state_out,
    output logic [6:0]  expired_count
);
    lrt_pkg::cmd_t  cmd;
    lrt_pkg::stat_t st;

    assign cfg_ready = 1'b1;

    lrt_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
        .out_valid(out_valid), .out_ready(out_ready), .st(st), .cmd(cmd));

    lrt_datapath #(.TABLE_DEPTH(TABLE_DEPTH)) u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .st(st),
        .cfg_valid(cfg_valid), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .mode(mode), .request_key(request_key), .requester_id(requester_id),
        .service_id(service_id), .authorized(authorized), .lease_slot(lease_slot),
        .now_ms(now_ms), .ok(ok), .status(status), .slot_out(slot_out),
        .duplicate(duplicate), .expires_at(expires_at),
        .lease_state_out(lease_state_out), .expired_count(expired_count));
endmodule

>>> design/lrt_ram.sv
// Generic single-port RAM with registered read.
// No dependencies.
module lrt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // Registered read; a write to the same address returns the old contents.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule

>>> design/lrt_ctrl.sv
// Controller state machine for the lease reservation table.
// Depends on lrt_pkg.
module lrt_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    output logic          out_valid,
    input  logic          out_ready,
    input  lrt_pkg::stat_t st,
    output lrt_pkg::cmd_t  cmd
);
    lrt_pkg::ctrl_state_t state_reg, state_next;
    logic out_valid_reg, out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= lrt_pkg::S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

    // Next state and commands.
    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd            = '0;
        in_ready       = 1'b0;
        case (state_reg)
            lrt_pkg::S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = lrt_pkg::S_DECODE;
                end
            end
            lrt_pkg::S_DECODE:
            begin
                cmd.scan_start = 1'b1;
                if (st.mode == lrt_pkg::MODE_RESERVE && !st.auth)
                begin
                    cmd.finish_simple = 1'b1;
                    state_next = lrt_pkg::S_DONE;
                end
                else if (st.mode == lrt_pkg::MODE_COMMIT
                         || st.mode == lrt_pkg::MODE_RELEASE)
                begin
                    state_next = lrt_pkg::S_SLOT_RD;
                end
                else if ((st.mode == lrt_pkg::MODE_RESERVE
                          || st.mode == lrt_pkg::MODE_CLEANUP
                          || st.mode == lrt_pkg::MODE_RELEASE_ALL) && !st.empty)
                begin
                    state_next = lrt_pkg::S_SCAN_RD;
                end
                else if (st.mode == lrt_pkg::MODE_RESERVE)
                begin
                    state_next = lrt_pkg::S_RESERVE_DECIDE;
                end
                else
                begin
                    cmd.finish_simple = 1'b1;
                    state_next = lrt_pkg::S_DONE;
                end
            end
            lrt_pkg::S_SCAN_RD:
            begin
                cmd.scan_read = 1'b1;
                state_next    = lrt_pkg::S_SCAN_EV;
            end
            lrt_pkg::S_SCAN_EV:
            begin
                cmd.scan_eval = 1'b1;
                if (st.scan_last)
                begin
                    if (st.mode == lrt_pkg::MODE_RESERVE)
                    begin
                        state_next = lrt_pkg::S_RESERVE_DECIDE;
                    end
                    else
                    begin
                        state_next = lrt_pkg::S_DONE;
                    end
                end
                else
                begin
                    state_next = lrt_pkg::S_SCAN_RD;
                end
            end
            lrt_pkg::S_RESERVE_DECIDE:
            begin
                cmd.decide = 1'b1;
                state_next = lrt_pkg::S_DONE;
            end
            lrt_pkg::S_SLOT_RD:
            begin
                cmd.slot_read = 1'b1;
                if (!st.slot_valid)
                begin
                    cmd.finish_simple = 1'b1;
                    state_next = lrt_pkg::S_DONE;
                end
                else
                begin
                    state_next = lrt_pkg::S_SLOT_EV;
                end
            end
            lrt_pkg::S_SLOT_EV:
            begin
                cmd.slot_eval = 1'b1;
                state_next    = lrt_pkg::S_DONE;
            end
            lrt_pkg::S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = lrt_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = lrt_pkg::S_IDLE;
            end
        endcase
    end
endmodule

>>> design/lrt_datapath.sv
// Datapath of the lease reservation table: lease memories, scan counters,
// result registers and configuration registers. Depends on lrt_pkg, lrt_ram.
module lrt_datapath #(
    parameter int TABLE_DEPTH = lrt_pkg::TABLE_DEPTH_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  lrt_pkg::cmd_t  cmd,
    output lrt_pkg::stat_t st,
    input  logic          cfg_valid,
    input  logic [1:0]    cfg_index,
    input  logic [31:0]   cfg_data,
    input  logic [2:0]    mode,
    input  logic [31:0]   request_key,
    input  logic [15:0]   requester_id,
    input  logic [15:0]   service_id,
    input  logic          authorized,
    input  logic [5:0]    lease_slot,
    input  logic [47:0]   now_ms,
    output logic          ok,
    output logic [2:0]    status,
    output logic [5:0]    slot_out,
    output logic          duplicate,
    output logic [48:0]   expires_at,
    output logic [1:0]    lease_state_out,
    output logic [6:0]    expired_count
);
    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    // Width wide enough for the counts, the 7-bit limits and the 6-bit slot.
    localparam int LW = (CW > 7) ? CW : 7;
    localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

    // Configuration registers.
    logic [6:0]  glim_reg, rlim_reg, slim_reg;
    logic [31:0] ltime_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            glim_reg  <= lrt_pkg::LIMIT_RESET;
            rlim_reg  <= lrt_pkg::LIMIT_RESET;
            slim_reg  <= lrt_pkg::LIMIT_RESET;
            ltime_reg <= lrt_pkg::LEASE_TIME_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                lrt_pkg::CFG_GLOBAL:    glim_reg  <= cfg_data[6:0];
                lrt_pkg::CFG_REQUESTER: rlim_reg  <= cfg_data[6:0];
                lrt_pkg::CFG_SERVICE:   slim_reg  <= cfg_data[6:0];
                lrt_pkg::CFG_LEASE:     ltime_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Captured item.
    logic [2:0]  mode_reg;
    logic [31:0] key_reg;
    logic [15:0] req_reg, svc_reg;
    logic        auth_reg;
    logic [5:0]  slot_reg;
    logic [47:0] now_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            mode_reg <= mode;
            key_reg  <= request_key;
            req_reg  <= requester_id;
            svc_reg  <= service_id;
            auth_reg <= authorized;
            slot_reg <= lease_slot;
            now_reg  <= now_ms;
        end
    end

    // Fill count and scan counters.
    logic [CW-1:0] used_reg, used_next;
    logic [AW-1:0] idx_reg, idx_next;
    logic [CW-1:0] g_reg, g_next, r_reg, r_next, s_reg, s_next;
    logic [6:0]    exp_reg, exp_next;
    logic          hit_reg, hit_next;

    // Memory ports.
    logic          ram_addr_unused;
    logic [AW-1:0] ram_addr;
    logic [31:0]   k_wd, k_rd;
    logic [15:0]   rq_wd, rq_rd, sv_wd, sv_rd;
    logic [48:0]   ex_wd, ex_rd;
    logic [1:0]    sd_wd, sd_rd;
    logic          key_we, st_we;

    assign ram_addr_unused = 1'b0;

    lrt_ram #(.WIDTH(32), .DEPTH(TABLE_DEPTH)) u_key (
        .clk(clk), .we(key_we), .addr(ram_addr), .wdata(k_wd), .rdata(k_rd));
    lrt_ram #(.WIDTH(16), .DEPTH(TABLE_DEPTH)) u_req (
        .clk(clk), .we(key_we), .addr(ram_addr), .wdata(rq_wd), .rdata(rq_rd));
    lrt_ram #(.WIDTH(16), .DEPTH(TABLE_DEPTH)) u_svc (
        .clk(clk), .we(key_we), .addr(ram_addr), .wdata(sv_wd), .rdata(sv_rd));
    lrt_ram #(.WIDTH(49), .DEPTH(TABLE_DEPTH)) u_exp (
        .clk(clk), .we(key_we), .addr(ram_addr), .wdata(ex_wd), .rdata(ex_rd));
    lrt_ram #(.WIDTH(2), .DEPTH(TABLE_DEPTH)) u_st (
        .clk(clk), .we(st_we), .addr(ram_addr), .wdata(sd_wd), .rdata(sd_rd));

    // Result registers and the held result.
    logic        r_ok_reg, r_ok_next, r_dup_reg, r_dup_next;
    logic [2:0]  r_st_reg, r_st_next;
    logic [5:0]  r_slot_reg, r_slot_next;
    logic [48:0] r_ex_reg, r_ex_next;
    logic [1:0]  r_ls_reg, r_ls_next;
    logic [6:0]  r_cnt_reg, r_cnt_next;

    logic        o_ok_reg, o_dup_reg;
    logic [2:0]  o_st_reg;
    logic [5:0]  o_slot_reg;
    logic [48:0] o_ex_reg;
    logic [1:0]  o_ls_reg;
    logic [6:0]  o_cnt_reg;

    logic          live, tent_live, expired_t;
    logic [48:0]   new_exp;
    logic          under_limits;

    assign expired_t = (sd_rd == lrt_pkg::LS_TENTATIVE) && ({1'b0, now_reg} >= ex_rd);
    assign tent_live = (sd_rd == lrt_pkg::LS_TENTATIVE) && ({1'b0, now_reg} < ex_rd);
    assign live      = tent_live || (sd_rd == lrt_pkg::LS_COMMITTED);
    assign new_exp   = {1'b0, now_reg} + {17'd0, ltime_reg};

    // All three live counts must stay below their limits for a new lease.
    assign under_limits = (LW'(g_reg) < LW'(glim_reg)) && (LW'(r_reg) < LW'(rlim_reg))
                          && (LW'(s_reg) < LW'(slim_reg));

    assign st.mode       = mode_reg;
    assign st.auth       = auth_reg;
    assign st.empty      = (used_reg == '0);
    assign st.scan_last  = (CW'(idx_reg) == used_reg - CW'(1)) || hit_next;
    assign st.slot_valid = (LW'(slot_reg) < LW'(used_reg));

    // Scan, decide and write control.
    always_comb
    begin
        used_next    = used_reg;
        idx_next     = idx_reg;
        g_next       = g_reg;
        r_next       = r_reg;
        s_next       = s_reg;
        exp_next     = exp_reg;
        hit_next     = hit_reg;
        r_ok_next    = r_ok_reg;
        r_dup_next   = r_dup_reg;
        r_st_next    = r_st_reg;
        r_slot_next  = r_slot_reg;
        r_ex_next    = r_ex_reg;
        r_ls_next    = r_ls_reg;
        r_cnt_next   = r_cnt_reg;
        ram_addr     = idx_reg;
        key_we       = 1'b0;
        st_we        = 1'b0;
        k_wd         = key_reg;
        rq_wd        = req_reg;
        sv_wd        = svc_reg;
        ex_wd        = new_exp;
        sd_wd        = lrt_pkg::LS_TENTATIVE;

        if (cmd.scan_start)
        begin
            idx_next   = '0;
            g_next     = '0;
            r_next     = '0;
            s_next     = '0;
            exp_next   = '0;
            hit_next   = 1'b0;
            r_ok_next  = 1'b0;
            r_dup_next = 1'b0;
            r_st_next  = lrt_pkg::ST_OK;
            r_slot_next = '0;
            r_ex_next  = '0;
            r_ls_next  = '0;
            r_cnt_next = '0;
        end

        if (cmd.scan_read)
        begin
            ram_addr = idx_reg;
        end

        if (cmd.scan_eval)
        begin
            ram_addr = idx_reg;
            case (mode_reg)
                lrt_pkg::MODE_RESERVE:
                begin
                    if (k_rd == key_reg)
                    begin
                        hit_next     = 1'b1;
                        if (tent_live)
                        begin
                            r_ok_next   = 1'b1;
                            r_dup_next  = 1'b1;
                            r_slot_next = 6'(idx_reg);
                            r_ex_next   = ex_rd;
                            r_ls_next   = sd_rd;
                        end
                        else
                        begin
                            r_st_next = lrt_pkg::ST_NOT_LIVE;
                        end
                    end
                    if (live)
                    begin
                        g_next = g_reg + CW'(1);
                        if (rq_rd == req_reg) r_next = r_reg + CW'(1);
                        if (sv_rd == svc_reg) s_next = s_reg + CW'(1);
                    end
                end
                lrt_pkg::MODE_CLEANUP:
                begin
                    r_ok_next = 1'b1;
                    if (expired_t)
                    begin
                        st_we    = 1'b1;
                        sd_wd    = lrt_pkg::LS_EXPIRED;
                        exp_next = exp_reg + 7'd1;
                    end
                end
                default:
                begin
                    r_ok_next = 1'b1;
                    if (sd_rd == lrt_pkg::LS_TENTATIVE || sd_rd == lrt_pkg::LS_COMMITTED)
                    begin
                        st_we = 1'b1;
                        sd_wd = lrt_pkg::LS_RELEASED;
                    end
                end
            endcase
            idx_next   = idx_reg + AW'(1);
            r_cnt_next = (mode_reg == lrt_pkg::MODE_CLEANUP) ?
                         (expired_t ? exp_reg + 7'd1 : exp_reg) : 7'd0;
        end

        if (cmd.decide)
        begin
            ram_addr = AW'(used_reg);
            if (hit_reg)
            begin
                // Result already set during the scan.
            end
            else if (!under_limits)
            begin
                r_st_next = lrt_pkg::ST_CAPACITY;
            end
            else if (used_reg >= DEPTH_C)
            begin
                r_st_next = lrt_pkg::ST_FULL;
            end
            else
            begin
                key_we      = 1'b1;
                st_we       = 1'b1;
                sd_wd       = lrt_pkg::LS_TENTATIVE;
                used_next   = used_reg + CW'(1);
                r_ok_next   = 1'b1;
                r_st_next   = lrt_pkg::ST_OK;
                r_slot_next = 6'(used_reg);
                r_ex_next   = new_exp;
                r_ls_next   = lrt_pkg::LS_TENTATIVE;
            end
        end

        if (cmd.slot_read)
        begin
            ram_addr = AW'(slot_reg);
        end

        if (cmd.slot_eval)
        begin
            ram_addr    = AW'(slot_reg);
            r_slot_next = slot_reg;
            r_ex_next   = ex_rd;
            r_ls_next   = sd_rd;
            if (mode_reg == lrt_pkg::MODE_COMMIT)
            begin
                if (sd_rd == lrt_pkg::LS_COMMITTED)
                begin
                    r_ok_next  = 1'b1;
                    r_dup_next = 1'b1;
                end
                else if (sd_rd != lrt_pkg::LS_TENTATIVE || expired_t)
                begin
                    r_st_next = lrt_pkg::ST_EXPIRED;
                    if (sd_rd == lrt_pkg::LS_TENTATIVE)
                    begin
                        st_we     = 1'b1;
                        sd_wd     = lrt_pkg::LS_EXPIRED;
                        r_ls_next = lrt_pkg::LS_EXPIRED;
                    end
                end
                else
                begin
                    st_we     = 1'b1;
                    sd_wd     = lrt_pkg::LS_COMMITTED;
                    r_ls_next = lrt_pkg::LS_COMMITTED;
                    r_ok_next = 1'b1;
                end
            end
            else
            begin
                r_ok_next = 1'b1;
                if (sd_rd == lrt_pkg::LS_TENTATIVE || sd_rd == lrt_pkg::LS_COMMITTED)
                begin
                    st_we     = 1'b1;
                    sd_wd     = lrt_pkg::LS_RELEASED;
                    r_ls_next = lrt_pkg::LS_RELEASED;
                end
            end
        end

        if (cmd.finish_simple)
        begin
            r_ok_next   = 1'b0;
            r_dup_next  = 1'b0;
            r_slot_next = '0;
            r_ex_next   = '0;
            r_ls_next   = '0;
            r_cnt_next  = '0;
            case (mode_reg)
                lrt_pkg::MODE_RESERVE:
                    r_st_next = lrt_pkg::ST_AUTH;
                lrt_pkg::MODE_COMMIT, lrt_pkg::MODE_RELEASE:
                    r_st_next = lrt_pkg::ST_NOT_FOUND;
                lrt_pkg::MODE_CLEANUP, lrt_pkg::MODE_RELEASE_ALL:
                begin
                    r_st_next = lrt_pkg::ST_OK;
                    r_ok_next = 1'b1;
                end
                default:
                    r_st_next = lrt_pkg::ST_OK;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg <= '0;
        end
        else
        begin
            used_reg <= used_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg     <= idx_next;
        g_reg       <= g_next;
        r_reg       <= r_next;
        s_reg       <= s_next;
        exp_reg     <= exp_next;
        hit_reg     <= hit_next;
        r_ok_reg    <= r_ok_next;
        r_dup_reg   <= r_dup_next;
        r_st_reg    <= r_st_next;
        r_slot_reg  <= r_slot_next;
        r_ex_reg    <= r_ex_next;
        r_ls_reg    <= r_ls_next;
        r_cnt_reg   <= r_cnt_next;
    end

    // Output register, loaded when the result is handed off.
    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            o_ok_reg   <= r_ok_reg;
            o_dup_reg  <= r_dup_reg;
            o_st_reg   <= r_st_reg;
            o_slot_reg <= r_slot_reg;
            o_ex_reg   <= r_ex_reg;
            o_ls_reg   <= r_ls_reg;
            o_cnt_reg  <= r_cnt_reg;
        end
    end

    assign ok              = o_ok_reg;
    assign duplicate       = o_dup_reg;
    assign status          = o_st_reg;
    assign slot_out        = o_slot_reg;
    assign expires_at      = o_ex_reg;
    assign lease_state_out = o_ls_reg;
    assign expired_count   = o_cnt_reg;
endmodule
